### rtl/nearest_neighbor_pixel_replicator_defines.svh
// Assertion macros shared by the pixel replicator RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef NEAREST_NEIGHBOR_PIXEL_REPLICATOR_DEFINES_SVH
`define NEAREST_NEIGHBOR_PIXEL_REPLICATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NNPR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define NNPR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define NNPR_ASSERT(lbl, cond, msg)
`define NNPR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

### rtl/nnpr_pkg.sv
// Package for the nearest-neighbor pixel replicator: widths, constants,
// register codes, the queue entry type and the extent function. No dependencies.
package nnpr_pkg;

    localparam int RATIO_W         = 20;
    localparam int PITCH_W         = 18;
    localparam int SRC_W           = 12;
    localparam int COLOR_W         = 32;
    localparam int DEST_W          = 15;
    localparam int ADDR_W          = 32;
    localparam int DATA_W          = 32;
    localparam int CFG_ADDR_W      = 4;
    localparam int MAX_FACTOR      = 8;
    localparam int FRAC_BITS       = 16;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int EXT_W           = $clog2(MAX_FACTOR + 1);
    localparam int CNT_W           = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int PROD_W          = RATIO_W + SRC_W;
    localparam int SUM_W           = RATIO_W + FRAC_BITS + 1;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [RATIO_W-1:0] X_RATIO_RESET    = RATIO_W'(65536);
    localparam logic [RATIO_W-1:0] Y_RATIO_RESET    = RATIO_W'(65536);
    localparam logic [PITCH_W-1:0] DEST_PITCH_RESET = PITCH_W'(2560);

    typedef enum logic [1:0] {
        REG_X_RATIO    = 2'd0,
        REG_Y_RATIO    = 2'd1,
        REG_DEST_PITCH = 2'd2
    } nnpr_reg_t;

    typedef struct packed {
        logic [DEST_W-1:0]  bx;
        logic [DEST_W-1:0]  by;
        logic [COLOR_W-1:0] color;
        logic [EXT_W-1:0]   nx;
        logic [EXT_W-1:0]   ny;
    } nnpr_entry_t;

    function automatic logic [EXT_W-1:0] extent(input logic [RATIO_W-1:0] ratio);
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] ceil_v;
        sum    = SUM_W'(ratio) + (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);
        ceil_v = sum >> FRAC_BITS;
        if (ceil_v > SUM_W'(MAX_FACTOR))
            return EXT_W'(MAX_FACTOR);
        else
            return ceil_v[EXT_W-1:0];
    endfunction

endpackage

### rtl/nnpr_queue.sv
// Short queue of classified source pixels between front and back.
// Depends on nnpr_pkg for the entry type.
module nnpr_queue #(
    parameter int DEPTH = nnpr_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  nnpr_pkg::nnpr_entry_t push_data,
    output logic                 full,
    output logic                 head_valid,
    output nnpr_pkg::nnpr_entry_t head,
    input  logic                 pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nnpr_pkg::nnpr_entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/nnpr_front.sv
// Front end: takes source pixel transfers, computes block origin and extent,
// and queues every pixel whose block is not empty. Depends on nnpr_pkg.
module nnpr_front (
    input  logic                            in_valid,
    input  logic [nnpr_pkg::SRC_W-1:0]      src_x,
    input  logic [nnpr_pkg::SRC_W-1:0]      src_y,
    input  logic [nnpr_pkg::COLOR_W-1:0]    src_color,
    input  logic [nnpr_pkg::RATIO_W-1:0]    x_ratio,
    input  logic [nnpr_pkg::RATIO_W-1:0]    y_ratio,
    input  logic                            queue_full,
    output logic                            push,
    output nnpr_pkg::nnpr_entry_t           push_data
);

    logic [nnpr_pkg::PROD_W-1:0] prod_x, prod_y;
    logic [nnpr_pkg::PROD_W-1:0] org_x, org_y;
    logic [nnpr_pkg::EXT_W-1:0]  ext_x, ext_y;

    always_comb
    begin
        prod_x = nnpr_pkg::PROD_W'(x_ratio) * nnpr_pkg::PROD_W'(src_x);
        prod_y = nnpr_pkg::PROD_W'(y_ratio) * nnpr_pkg::PROD_W'(src_y);
        org_x  = prod_x >> nnpr_pkg::FRAC_BITS;
        org_y  = prod_y >> nnpr_pkg::FRAC_BITS;
        ext_x  = nnpr_pkg::extent(x_ratio);
        ext_y  = nnpr_pkg::extent(y_ratio);

        push_data.bx    = org_x[nnpr_pkg::DEST_W-1:0];
        push_data.by    = org_y[nnpr_pkg::DEST_W-1:0];
        push_data.color = src_color;
        push_data.nx    = ext_x;
        push_data.ny    = ext_y;

        // A zero ratio gives an empty block, so the transfer is consumed here.
        push = in_valid && !queue_full && (ext_x != '0) && (ext_y != '0);
    end

endmodule

### rtl/nnpr_back.sv
// Back end: walks the block of the queue head in row-major order and drives
// the registered destination write channel. Depends on nnpr_pkg and the defines.
`include "nearest_neighbor_pixel_replicator_defines.svh"

module nnpr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  nnpr_pkg::nnpr_entry_t           q_head,
    output logic                            q_pop,
    input  logic [nnpr_pkg::PITCH_W-1:0]    dest_pitch,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [nnpr_pkg::DEST_W-1:0]     dest_x,
    output logic [nnpr_pkg::DEST_W-1:0]     dest_y,
    output logic [nnpr_pkg::ADDR_W-1:0]     byte_address,
    output logic [nnpr_pkg::COLOR_W-1:0]    pixel_color,
    output logic                            last_write
);

    localparam int ROW_W = nnpr_pkg::DEST_W + nnpr_pkg::PITCH_W;

    logic [nnpr_pkg::CNT_W-1:0]   ox_reg, ox_next;
    logic [nnpr_pkg::CNT_W-1:0]   oy_reg, oy_next;
    logic                         out_valid_reg, out_valid_next;
    logic [nnpr_pkg::DEST_W-1:0]  dest_x_reg, dest_y_reg;
    logic [nnpr_pkg::ADDR_W-1:0]  addr_reg;
    logic [nnpr_pkg::COLOR_W-1:0] color_reg;
    logic                         last_reg;

    logic                         advance, emit, last_x, last_y;
    logic [nnpr_pkg::DEST_W-1:0]  dx, dy;
    logic [ROW_W-1:0]             row_off;
    logic [nnpr_pkg::ADDR_W-1:0]  addr;

    always_comb
    begin
        advance = !out_valid_reg || !out_stall;
        emit    = advance && q_valid;
        last_x  = ({1'b0, ox_reg} == (q_head.nx - nnpr_pkg::EXT_W'(1)));
        last_y  = ({1'b0, oy_reg} == (q_head.ny - nnpr_pkg::EXT_W'(1)));
        q_pop   = emit && last_x && last_y;

        dx      = q_head.bx + nnpr_pkg::DEST_W'(ox_reg);
        dy      = q_head.by + nnpr_pkg::DEST_W'(oy_reg);
        row_off = ROW_W'(dy) * ROW_W'(dest_pitch);
        addr    = nnpr_pkg::ADDR_W'(row_off)
                + nnpr_pkg::ADDR_W'(dx) * nnpr_pkg::ADDR_W'(nnpr_pkg::BYTES_PER_PIXEL);

        ox_next = ox_reg;
        oy_next = oy_reg;
        if (emit)
        begin
            if (last_x)
            begin
                ox_next = '0;
                oy_next = last_y ? '0 : oy_reg + nnpr_pkg::CNT_W'(1);
            end
            else
            begin
                ox_next = ox_reg + nnpr_pkg::CNT_W'(1);
            end
        end
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg        <= '0;
            oy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            dest_x_reg <= dx;
            dest_y_reg <= dy;
            addr_reg   <= addr;
            color_reg  <= q_head.color;
            last_reg   <= last_x && last_y;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_x       = dest_x_reg;
    assign dest_y       = dest_y_reg;
    assign byte_address = addr_reg;
    assign pixel_color  = color_reg;
    assign last_write   = last_reg;

    `NNPR_ASSERT_IMPL(a_head_not_empty, q_valid, (q_head.nx != '0) && (q_head.ny != '0), "empty block queued")
    `NNPR_ASSERT_IMPL(a_ox_in_range, q_valid, ({1'b0, ox_reg} < q_head.nx), "column counter out of block")
    `NNPR_ASSERT_IMPL(a_oy_in_range, q_valid, ({1'b0, oy_reg} < q_head.ny), "row counter out of block")
    `NNPR_ASSERT_IMPL(a_idle_counters, !q_valid, (ox_reg == '0) && (oy_reg == '0), "counters not rewound")

endmodule

### rtl/nearest_neighbor_pixel_replicator.sv
// Top level of the nearest-neighbor pixel replicator: configuration registers,
// front end, queue and back end. Depends on nnpr_pkg and the nnpr_* modules.
//
//  Channel  Handshake                  Payload
//  in       in_valid / in_stall        src_x, src_y, src_color
//  out      out_valid / out_stall      dest_x, dest_y, byte_address, pixel_color, last_write
//  cfg      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A source pixel gives ceil(y_ratio) * ceil(x_ratio) destination writes (each side at most
// MAX_FACTOR); the back end issues one write per cycle while out_stall does not hold it.
// A pixel whose block is empty never enters the queue and gives no write.
// The input stalls only while the queue is full; the output stalls only the back end.
// Reset loads the default ratios of 1.0 and a pitch of 2560 bytes and empties the queue.
module nearest_neighbor_pixel_replicator #(
    parameter int QUEUE_DEPTH = nnpr_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nnpr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [nnpr_pkg::DATA_W-1:0]     pwdata,
    output logic [nnpr_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [nnpr_pkg::SRC_W-1:0]      src_x,
    input  logic [nnpr_pkg::SRC_W-1:0]      src_y,
    input  logic [nnpr_pkg::COLOR_W-1:0]    src_color,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [nnpr_pkg::DEST_W-1:0]     dest_x,
    output logic [nnpr_pkg::DEST_W-1:0]     dest_y,
    output logic [nnpr_pkg::ADDR_W-1:0]     byte_address,
    output logic [nnpr_pkg::COLOR_W-1:0]    pixel_color,
    output logic                            last_write
);

    logic [nnpr_pkg::RATIO_W-1:0] x_ratio_reg, x_ratio_next;
    logic [nnpr_pkg::RATIO_W-1:0] y_ratio_reg, y_ratio_next;
    logic [nnpr_pkg::PITCH_W-1:0] pitch_reg, pitch_next;
    nnpr_pkg::nnpr_reg_t          reg_sel;
    logic                         cfg_write;

    logic                         push, queue_full, q_valid, q_pop;
    nnpr_pkg::nnpr_entry_t        push_data, q_head;

    assign pready    = 1'b1;
    assign reg_sel   = nnpr_pkg::nnpr_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        x_ratio_next = x_ratio_reg;
        y_ratio_next = y_ratio_reg;
        pitch_next   = pitch_reg;
        prdata       = '0;
        case (reg_sel)
            nnpr_pkg::REG_X_RATIO:
            begin
                prdata = nnpr_pkg::DATA_W'(x_ratio_reg);
                if (cfg_write)
                    x_ratio_next = pwdata[nnpr_pkg::RATIO_W-1:0];
            end
            nnpr_pkg::REG_Y_RATIO:
            begin
                prdata = nnpr_pkg::DATA_W'(y_ratio_reg);
                if (cfg_write)
                    y_ratio_next = pwdata[nnpr_pkg::RATIO_W-1:0];
            end
            nnpr_pkg::REG_DEST_PITCH:
            begin
                prdata = nnpr_pkg::DATA_W'(pitch_reg);
                if (cfg_write)
                    pitch_next = pwdata[nnpr_pkg::PITCH_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_ratio_reg <= nnpr_pkg::X_RATIO_RESET;
            y_ratio_reg <= nnpr_pkg::Y_RATIO_RESET;
            pitch_reg   <= nnpr_pkg::DEST_PITCH_RESET;
        end
        else
        begin
            x_ratio_reg <= x_ratio_next;
            y_ratio_reg <= y_ratio_next;
            pitch_reg   <= pitch_next;
        end
    end

    assign in_stall = queue_full;

    nnpr_front u_front (
        .in_valid   (in_valid),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_color  (src_color),
        .x_ratio    (x_ratio_reg),
        .y_ratio    (y_ratio_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    nnpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    nnpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .dest_pitch   (pitch_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .byte_address (byte_address),
        .pixel_color  (pixel_color),
        .last_write   (last_write)
    );

endmodule

### tb/tb_nearest_neighbor_pixel_replicator.sv
// Self-checking testbench for nearest_neighbor_pixel_replicator: drives source pixels and
// register writes, predicts each destination write and compares it field by field.
// Depends on nnpr_pkg and the replicator RTL only.
module tb_nearest_neighbor_pixel_replicator;

    localparam int FRAC_BITS       = nnpr_pkg::FRAC_BITS;
    localparam int MAX_FACTOR      = nnpr_pkg::MAX_FACTOR;
    localparam int BYTES_PER_PIXEL = nnpr_pkg::BYTES_PER_PIXEL;
    localparam int CFG_ADDR_W      = nnpr_pkg::CFG_ADDR_W;
    localparam int DATA_W          = nnpr_pkg::DATA_W;
    localparam int SRC_W           = nnpr_pkg::SRC_W;
    localparam int COLOR_W         = nnpr_pkg::COLOR_W;
    localparam int DEST_W          = nnpr_pkg::DEST_W;
    localparam int ADDR_W          = nnpr_pkg::ADDR_W;
    localparam int RATIO_W         = nnpr_pkg::RATIO_W;
    localparam int PITCH_W         = nnpr_pkg::PITCH_W;

    localparam int ONE            = 1 << FRAC_BITS;
    localparam int QUIET_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [CFG_ADDR_W-1:0] UNUSED_REG_ADDR = CFG_ADDR_W'(12);

    typedef struct {
        logic [SRC_W-1:0]   x;
        logic [SRC_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } src_pixel_t;

    typedef struct {
        logic [DEST_W-1:0]  dest_x;
        logic [DEST_W-1:0]  dest_y;
        logic [ADDR_W-1:0]  byte_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_write;
    } dest_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SRC_W-1:0]      src_x = '0;
    logic [SRC_W-1:0]      src_y = '0;
    logic [COLOR_W-1:0]    src_color = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DEST_W-1:0]     dest_x;
    logic [DEST_W-1:0]     dest_y;
    logic [ADDR_W-1:0]     byte_address;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  last_write;

    logic [RATIO_W-1:0] cur_x_ratio = nnpr_pkg::X_RATIO_RESET;
    logic [RATIO_W-1:0] cur_y_ratio = nnpr_pkg::Y_RATIO_RESET;
    logic [PITCH_W-1:0] cur_pitch   = nnpr_pkg::DEST_PITCH_RESET;

    src_pixel_t  pixel_q[$];
    dest_write_t pending_writes[$];
    src_pixel_t  next_pixel;
    dest_write_t want;
    int          pixels_queued = 0;
    int          pixels_sent = 0;
    int          writes_seen = 0;
    int          in_wait = 0;
    int          out_wait = 0;
    int          idle_cycles = 0;
    int          failures = 0;

    nearest_neighbor_pixel_replicator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .src_x        (src_x),
        .src_y        (src_y),
        .src_color    (src_color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .byte_address (byte_address),
        .pixel_color  (pixel_color),
        .last_write   (last_write)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void report_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    // Block size on one axis: ceil(ratio), saturating at MAX_FACTOR.
    function automatic int unsigned block_span(input logic [RATIO_W-1:0] ratio);
        longint unsigned c;
        c = (longint'(ratio) + ONE - 1) >> FRAC_BITS;
        return (c > MAX_FACTOR) ? MAX_FACTOR : int'(c);
    endfunction

    function automatic void predict_writes(input logic [SRC_W-1:0] sx,
                                           input logic [SRC_W-1:0] sy,
                                           input logic [COLOR_W-1:0] color);
        int unsigned     nx;
        int unsigned     ny;
        logic [31:0]     bx;
        logic [31:0]     by;
        longint unsigned addr;
        dest_write_t     w;
        nx = block_span(cur_x_ratio);
        ny = block_span(cur_y_ratio);
        bx = 32'((64'(cur_x_ratio) * 64'(sx)) >> FRAC_BITS);
        by = 32'((64'(cur_y_ratio) * 64'(sy)) >> FRAC_BITS);
        for (int unsigned oy = 0; oy < ny; oy++)
        begin
            for (int unsigned ox = 0; ox < nx; ox++)
            begin
                w.dest_x       = DEST_W'(bx + ox);
                w.dest_y       = DEST_W'(by + oy);
                addr           = 64'(w.dest_y) * 64'(cur_pitch)
                               + 64'(w.dest_x) * BYTES_PER_PIXEL;
                w.byte_address = addr[ADDR_W-1:0];
                w.pixel_color  = color;
                w.last_write   = (oy == ny - 1) && (ox == nx - 1);
                pending_writes.push_back(w);
            end
        end
    endfunction

    // Alternate stretches of back-to-back traffic with stretches of random gaps.
    function automatic int pick_gap(input int count, input int stretch);
        return ((count / stretch) % 2 == 1) ? 0 : int'($urandom_range(0, 19));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_wait = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_writes(src_x, src_y, src_color);
                pixels_sent++;
                in_wait = pick_gap(pixels_sent, 24);
            end
            if (!in_valid || !in_stall)
            begin
                if (in_wait > 0)
                begin
                    in_wait--;
                    in_valid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    next_pixel = pixel_q.pop_front();
                    src_x     <= next_pixel.x;
                    src_y     <= next_pixel.y;
                    src_color <= next_pixel.color;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                writes_seen++;
                if (pending_writes.size() == 0)
                begin
                    report_failure($sformatf(
                        "unexpected write: x=%0d y=%0d addr=%h color=%h last=%0b",
                        dest_x, dest_y, byte_address, pixel_color, last_write));
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (dest_x !== want.dest_x || dest_y !== want.dest_y
                        || byte_address !== want.byte_address
                        || pixel_color !== want.pixel_color
                        || last_write !== want.last_write)
                        report_failure($sformatf(
                            {"write mismatch: expected x=%0d y=%0d addr=%h color=%h last=%0b,",
                             " got x=%0d y=%0d addr=%h color=%h last=%0b"},
                            want.dest_x, want.dest_y, want.byte_address, want.pixel_color,
                            want.last_write, dest_x, dest_y, byte_address, pixel_color,
                            last_write));
                end
                out_wait = pick_gap(writes_seen, 48);
            end
            if (out_wait > 0)
            begin
                out_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired after %0d cycles without a transfer", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [CFG_ADDR_W-1:0] reg_addr(input nnpr_pkg::nnpr_reg_t r);
        return CFG_ADDR_W'(4 * int'(r));
    endfunction

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == reg_addr(nnpr_pkg::REG_X_RATIO))
            cur_x_ratio = data[RATIO_W-1:0];
        else if (addr == reg_addr(nnpr_pkg::REG_Y_RATIO))
            cur_y_ratio = data[RATIO_W-1:0];
        else if (addr == reg_addr(nnpr_pkg::REG_DEST_PITCH))
            cur_pitch = data[PITCH_W-1:0];
    endtask

    task automatic reg_check(input nnpr_pkg::nnpr_reg_t r, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(r);
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        if (prdata !== value)
            report_failure($sformatf("register %s read mismatch: expected %h, got %h",
                                     r.name(), value, prdata));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        reg_check(nnpr_pkg::REG_X_RATIO, DATA_W'(cur_x_ratio));
        reg_check(nnpr_pkg::REG_Y_RATIO, DATA_W'(cur_y_ratio));
        reg_check(nnpr_pkg::REG_DEST_PITCH, DATA_W'(cur_pitch));
    endtask

    task automatic set_config(input logic [RATIO_W-1:0] xr, input logic [RATIO_W-1:0] yr,
                              input logic [PITCH_W-1:0] pitch);
        reg_write(reg_addr(nnpr_pkg::REG_X_RATIO), DATA_W'(xr));
        reg_write(reg_addr(nnpr_pkg::REG_Y_RATIO), DATA_W'(yr));
        reg_write(reg_addr(nnpr_pkg::REG_DEST_PITCH), DATA_W'(pitch));
        check_registers();
    endtask

    task automatic send(input logic [SRC_W-1:0] x, input logic [SRC_W-1:0] y,
                        input logic [COLOR_W-1:0] color);
        src_pixel_t p;
        p.x     = x;
        p.y     = y;
        p.color = color;
        pixel_q.push_back(p);
        pixels_queued++;
    endtask

    // Blocks until every pixel has been taken and every write has come back, then lets the
    // pipeline settle so that pixels with an empty block have drained too.
    task automatic finish_phase();
        while (pixels_sent != pixels_queued || pending_writes.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    function automatic logic [RATIO_W-1:0] pick_ratio();
        case ($urandom_range(0, 7))
            0:       return RATIO_W'($urandom_range(1, ONE));
            1, 2:    return RATIO_W'($urandom_range(ONE + 1, 4 * ONE));
            3:       return RATIO_W'($urandom_range(1, 4) * ONE);
            4, 5:    return RATIO_W'($urandom_range(0, (1 << RATIO_W) - 1));
            6:       return RATIO_W'($urandom_range(ONE / 2, 2 * ONE));
            default: return '0;
        endcase
    endfunction

    function automatic logic [PITCH_W-1:0] pick_pitch();
        case ($urandom_range(0, 3))
            0:       return PITCH_W'($urandom_range(0, (1 << PITCH_W) - 1));
            1:       return '0;
            default: return PITCH_W'(4 * $urandom_range(1, 8192));
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        check_registers();
        send(12'd0, 12'd0, 32'h0000_0000);
        send(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        send(12'hAAA, 12'h555, 32'hA5A5_A5A5);
        send(12'h555, 12'hAAA, 32'h5A5A_5A5A);
        finish_phase();

        set_config(RATIO_W'(2 * ONE), RATIO_W'(2 * ONE), PITCH_W'(5120));
        send(12'd0, 12'd0, 32'h1234_5678);
        send(12'd17, 12'd33, 32'h8765_4321);
        send(12'hFFF, 12'hFFF, 32'hCAFE_F00D);
        finish_phase();

        // Saturated extents, wrapping coordinates and wrapping addresses.
        set_config(RATIO_W'((1 << RATIO_W) - 1), RATIO_W'((1 << RATIO_W) - 1),
                   PITCH_W'((1 << PITCH_W) - 1));
        send(12'hFFF, 12'hFFF, 32'hDEAD_BEEF);
        send(12'd0, 12'd0, 32'h0F0F_0F0F);
        send(12'd1234, 12'd3000, 32'hF0F0_F0F0);
        finish_phase();

        // A zero ratio on either axis yields an empty block.
        set_config(RATIO_W'(0), RATIO_W'(3 * ONE), PITCH_W'(2560));
        send(12'd10, 12'd20, 32'h1111_1111);
        send(12'hFFF, 12'd0, 32'h2222_2222);
        finish_phase();
        set_config(RATIO_W'(5 * ONE), RATIO_W'(0), PITCH_W'(2560));
        send(12'd100, 12'd200, 32'h3333_3333);
        finish_phase();

        // Smallest ratio and zero pitch; a write to an unused address must change nothing.
        set_config(RATIO_W'(1), RATIO_W'(1), PITCH_W'(0));
        reg_write(UNUSED_REG_ADDR, 32'hFFFF_FFFF);
        check_registers();
        send(12'hFFF, 12'hFFF, 32'h4444_4444);
        send(12'd7, 12'd9, 32'h5555_5555);
        finish_phase();

        set_config(RATIO_W'(ONE / 2), RATIO_W'(8 * ONE + 1), PITCH_W'(640));
        send(12'd1, 12'd1, 32'h6666_6666);
        send(12'd2, 12'd3, 32'h7777_7777);
        send(12'hFFF, 12'hFFF, 32'h8888_8888);
        finish_phase();

        set_config(RATIO_W'(8 * ONE), RATIO_W'(7 * ONE + 1), PITCH_W'(32768));
        send(12'd4095, 12'd1, 32'h9999_9999);
        send(12'd3, 12'd4095, 32'hAAAA_AAAA);
        finish_phase();

        for (int phase = 0; phase < 8; phase++)
        begin
            set_config(pick_ratio(), pick_ratio(), pick_pitch());
            for (int i = 0; i < 20; i++)
                send(SRC_W'($urandom_range(0, (1 << SRC_W) - 1)),
                     SRC_W'($urandom_range(0, (1 << SRC_W) - 1)), $urandom());
            finish_phase();
        end

        if (pending_writes.size() != 0)
            report_failure($sformatf("%0d expected writes never arrived", pending_writes.size()));
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
